/* rtl/swm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg
// shared constants and controller/datapath interface types for the
// sliding window maximum core
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int MAX_WINDOW_DEF = 64;
    localparam int DATA_W         = 32;
    localparam int WSIZE_W        = 7;
    localparam int APB_ADDR_W     = 2;
    localparam int APB_DATA_W     = 32;

    localparam logic [WSIZE_W-1:0]    WSIZE_RESET    = 7'd1;
    localparam logic [APB_ADDR_W-1:0] ADDR_WIN_SIZE  = 2'd0;

    typedef struct packed {
        logic load;
        logic rd_head;
        logic rd_tail;
        logic pop_head;
        logic pop_tail;
        logic append;
        logic out_load;
    } swm_cmd_t;

    typedef struct packed {
        logic win_zero;
        logic occ_zero;
        logic expire_hit;
        logic drop_hit;
        logic result_ok;
        logic out_busy;
    } swm_status_t;

endpackage

/* rtl/swm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module swm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/swm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_ctrl
// sequencer for one item (a zero window only loads it): expire front entries, drop back entries,
// append, then, once the window has filled, read the front for the result
// ----------------------------------------------------------------------------
module swm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  swm_pkg::swm_status_t status,
    output swm_pkg::swm_cmd_t    cmd
);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_EXP_RD   = 8'b0000_0010,
        ST_EXP_CMP  = 8'b0000_0100,
        ST_DROP_RD  = 8'b0000_1000,
        ST_DROP_CMP = 8'b0001_0000,
        ST_APPEND   = 8'b0010_0000,
        ST_OUT_RD   = 8'b0100_0000,
        ST_OUT_WAIT = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    if (!status.win_zero)
                    begin
                        state_next = ST_EXP_RD;
                    end
                end
            end
            ST_EXP_RD:
            begin
                if (status.occ_zero)
                begin
                    state_next = ST_DROP_RD;
                end
                else
                begin
                    cmd.rd_head = 1'b1;
                    state_next  = ST_EXP_CMP;
                end
            end
            ST_EXP_CMP:
            begin
                if (status.expire_hit)
                begin
                    cmd.pop_head = 1'b1;
                    state_next   = ST_EXP_RD;
                end
                else
                begin
                    state_next = ST_DROP_RD;
                end
            end
            ST_DROP_RD:
            begin
                if (status.occ_zero)
                begin
                    state_next = ST_APPEND;
                end
                else
                begin
                    cmd.rd_tail = 1'b1;
                    state_next  = ST_DROP_CMP;
                end
            end
            ST_DROP_CMP:
            begin
                if (status.drop_hit)
                begin
                    cmd.pop_tail = 1'b1;
                    state_next   = ST_DROP_RD;
                end
                else
                begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND:
            begin
                cmd.append = 1'b1;
                state_next = ST_OUT_RD;
            end
            ST_OUT_RD:
            begin
                if (status.result_ok)
                begin
                    cmd.rd_head = 1'b1;
                    state_next  = ST_OUT_WAIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT_WAIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/swm_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_datapath
// deque ring in ram, head/tail pointers, counters, compare logic and
// output register
// ----------------------------------------------------------------------------
module swm_datapath #(
    parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  swm_pkg::swm_cmd_t                   cmd,
    output swm_pkg::swm_status_t                status,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]     eff_win,
    input  logic signed [swm_pkg::DATA_W-1:0]   sample,
    input  logic                                start_req,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic signed [swm_pkg::DATA_W-1:0]   window_max
);

    localparam int IDX_W = $clog2(MAX_WINDOW);
    localparam int WIN_W = $clog2(MAX_WINDOW + 1);
    localparam int POS_W = $clog2(4 * MAX_WINDOW);
    localparam int RAM_W = swm_pkg::DATA_W + POS_W;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_WINDOW - 1);
    localparam logic [WIN_W-1:0] OCC_FULL = WIN_W'(MAX_WINDOW);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(4 * MAX_WINDOW - 1);
    localparam logic [POS_W:0]   POS_MOD  = (POS_W + 1)'(4 * MAX_WINDOW);

    logic signed [swm_pkg::DATA_W-1:0] sample_reg;
    logic [IDX_W-1:0]                  head_reg;
    logic [IDX_W-1:0]                  head_next;
    logic [IDX_W-1:0]                  tail_reg;
    logic [IDX_W-1:0]                  tail_next;
    logic [WIN_W-1:0]                  occ_reg;
    logic [WIN_W-1:0]                  occ_next;
    logic [POS_W-1:0]                  pos_reg;
    logic [POS_W-1:0]                  pos_next;
    logic [WIN_W-1:0]                  filled_reg;
    logic [WIN_W-1:0]                  filled_next;
    logic                              out_valid_reg;
    logic signed [swm_pkg::DATA_W-1:0] out_data_reg;

    logic [IDX_W-1:0]                  head_inc;
    logic [IDX_W-1:0]                  tail_inc;
    logic [IDX_W-1:0]                  tail_dec;
    logic                              ram_we;
    logic                              ram_re;
    logic [IDX_W-1:0]                  ram_raddr;
    logic [RAM_W-1:0]                  ram_wdata;
    logic [RAM_W-1:0]                  ram_rdata;
    logic signed [swm_pkg::DATA_W-1:0] rd_value;
    logic [POS_W-1:0]                  rd_pos;
    logic [POS_W:0]                    age_diff;
    logic [POS_W:0]                    age_wrap;
    logic [POS_W-1:0]                  age;

    assign head_inc = (head_reg == IDX_LAST) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == IDX_LAST) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? IDX_LAST : tail_reg - 1'b1;

    assign ram_we    = cmd.append && (occ_reg != OCC_FULL);
    assign ram_wdata = {pos_reg, sample_reg};
    assign ram_re    = cmd.rd_head || cmd.rd_tail;
    assign ram_raddr = cmd.rd_tail ? tail_dec : head_reg;

    swm_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_WINDOW)
    ) u_cand_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_value = ram_rdata[swm_pkg::DATA_W-1:0];
    assign rd_pos   = ram_rdata[swm_pkg::DATA_W +: POS_W];

    // age modulo the position range
    assign age_diff = {1'b0, pos_reg} - {1'b0, rd_pos};
    assign age_wrap = age_diff + POS_MOD;
    assign age      = age_diff[POS_W] ? age_wrap[POS_W-1:0] : age_diff[POS_W-1:0];

    assign status.win_zero   = (eff_win == '0);
    assign status.occ_zero   = (occ_reg == '0);
    assign status.expire_hit = (age >= POS_W'(eff_win));
    assign status.drop_hit   = (rd_value <= sample_reg);
    assign status.result_ok  = (filled_reg >= eff_win) && (occ_reg != '0);
    assign status.out_busy   = out_valid_reg && !m_tready;

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        occ_next    = occ_reg;
        pos_next    = pos_reg;
        filled_next = filled_reg;
        priority if (cmd.load && start_req)
        begin
            head_next   = '0;
            tail_next   = '0;
            occ_next    = '0;
            pos_next    = '0;
            filled_next = '0;
        end
        else if (cmd.pop_head)
        begin
            head_next = head_inc;
            occ_next  = occ_reg - 1'b1;
        end
        else if (cmd.pop_tail)
        begin
            tail_next = tail_dec;
            occ_next  = occ_reg - 1'b1;
        end
        else if (cmd.append)
        begin
            if (occ_reg != OCC_FULL)
            begin
                tail_next = tail_inc;
                occ_next  = occ_reg + 1'b1;
            end
            pos_next = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
            if (filled_reg < eff_win)
            begin
                filled_next = filled_reg + 1'b1;
            end
        end
        else
        begin
            head_next = head_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            pos_reg       <= '0;
            filled_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            occ_reg    <= occ_next;
            pos_reg    <= pos_next;
            filled_reg <= filled_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= sample;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= rd_value;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign window_max = out_data_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_FULL)
        else $error("deque occupancy above capacity");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty deque with head and tail apart");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pop_head || cmd.pop_tail) |-> (occ_reg != '0))
        else $error("pop from empty deque");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && !m_tready))
        else $error("result overwritten before taken");

endmodule

/* rtl/sliding_window_maximum_core.sv */
`timescale 1ns / 1ps
// each item: accept in idle, expire front entries, drop back entries, append,
// then read the front for the result once the window has filled; a zero
// window only loads the sample; a stalled output holds the core in the output
// wait state, so the next item waits; s_tready high only in idle
// reset: control, pointers and counters cleared, window_size set to 1;
// the candidate ram is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
// sliding_window_maximum_core
// running maximum over the last window_size samples (capped at MAX_WINDOW) using a monotonic deque
// ----------------------------------------------------------------------------
module sliding_window_maximum_core #(
    parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // apb configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [swm_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [swm_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [swm_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,   // [31:0] sample
    input  logic [0:0]                        s_tuser,   // [0] start_req
    // output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata    // [31:0] window_max
);

    localparam int WIN_W = $clog2(MAX_WINDOW + 1);

    logic [swm_pkg::WSIZE_W-1:0] window_size_reg;
    logic [WIN_W-1:0]            eff_win;
    logic                        cfg_wr;
    swm_pkg::swm_cmd_t           cmd;
    swm_pkg::swm_status_t        status;
    logic signed [31:0]          window_max;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr == swm_pkg::ADDR_WIN_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= swm_pkg::WSIZE_RESET;
        end
        else if (cfg_wr)
        begin
            window_size_reg <= pwdata[swm_pkg::WSIZE_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr == swm_pkg::ADDR_WIN_SIZE)
        begin
            prdata = swm_pkg::APB_DATA_W'(window_size_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    // clamp window to the deque capacity
    always_comb
    begin
        if (int'(window_size_reg) > MAX_WINDOW)
        begin
            eff_win = WIN_W'(MAX_WINDOW);
        end
        else
        begin
            eff_win = WIN_W'(window_size_reg);
        end
    end

    swm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    swm_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .eff_win    (eff_win),
        .sample     (s_tdata),
        .start_req  (s_tuser[0]),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .window_max (window_max)
    );

    assign m_tdata = window_max;

endmodule
